@@ rtl/rxcsum_pkg.sv @@
// Shared constants, types and arithmetic helpers for the receive checksum block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rxcsum_pkg;

   localparam int MAX_PACKET_BYTES = 2048;
   localparam int LANES            = 8;
   localparam int LANE_IDX_W       = $clog2(LANES);
   localparam int DATA_W           = 64;
   localparam int BYTE_W           = 8;
   localparam int COUNT_W          = 4;
   localparam int FIELD_W          = 11;
   localparam int LEN_W            = 12;
   localparam int CSUM_W           = 16;
   localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
   localparam int LANE_POS_W       = POS_W + 1;
   localparam int SLOT_W           = FIELD_W + 1;
   localparam int SUM_W            = CSUM_W + LANE_IDX_W;

   // Byte lane controls that all lanes share for one item.
   typedef struct packed {
      logic [POS_W-1:0]   base_pos;
      logic [FIELD_W-1:0] start;
      logic [COUNT_W-1:0] count;
   } lane_ctrl_type;

   // Ones'-complement add with end-around carry.
   function automatic logic [CSUM_W-1:0] csum_add(input logic [CSUM_W-1:0] a,
                                                  input logic [CSUM_W-1:0] b);
      logic [CSUM_W:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[CSUM_W-1:0] + {{(CSUM_W-1){1'b0}}, t[CSUM_W]};
   endfunction

endpackage

`default_nettype wire

@@ rtl/rxcsum_req_if.sv @@
// Input channel of the receive checksum block: valid, ready and one packet word.
// Depends on rxcsum_pkg for the field widths.
`default_nettype none

interface rxcsum_req_if;
   import rxcsum_pkg::*;

   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  data_word;
   logic [COUNT_W-1:0] byte_count;
   logic               first_word;
   logic               last_word;
   logic               needs_csum;
   logic [FIELD_W-1:0] start_byte;
   logic [FIELD_W-1:0] slot_offset;

   modport source (output valid, data_word, byte_count, first_word, last_word,
                   needs_csum, start_byte, slot_offset, input ready);
   modport sink   (input valid, data_word, byte_count, first_word, last_word,
                   needs_csum, start_byte, slot_offset, output ready);
endinterface

`default_nettype wire

@@ rtl/rxcsum_rsp_if.sv @@
// Result channel of the receive checksum block: valid, ready and one result.
// Depends on rxcsum_pkg for the field widths.
`default_nettype none

interface rxcsum_rsp_if;
   import rxcsum_pkg::*;

   logic               valid;
   logic               ready;
   logic [CSUM_W-1:0]  checksum;
   logic [FIELD_W-1:0] insert_offset;
   logic               apply_csum;
   logic               header_error;
   logic [LEN_W-1:0]   packet_length;

   modport source (output valid, checksum, insert_offset, apply_csum, header_error,
                   packet_length, input ready);
   modport sink   (input valid, checksum, insert_offset, apply_csum, header_error,
                   packet_length, output ready);
endinterface

`default_nettype wire

@@ rtl/rxcsum_lane.sv @@
// One byte lane: places its byte in the low or high half of a 16-bit word.
// Depends on rxcsum_pkg for the lane control struct and widths.
`default_nettype none

module rxcsum_lane (
   input  rxcsum_pkg::lane_ctrl_type          ctrl,
   input  logic [rxcsum_pkg::LANE_IDX_W-1:0]  lane_idx,
   input  logic [rxcsum_pkg::BYTE_W-1:0]      byte_in,
   output logic [rxcsum_pkg::CSUM_W-1:0]      value
);
   import rxcsum_pkg::*;

   localparam int CMP_W = (LANE_POS_W > SLOT_W) ? LANE_POS_W : SLOT_W;

   logic [LANE_POS_W-1:0] pos;
   logic                  in_word;
   logic                  in_range;
   logic                  summed;
   logic                  high_half;

   always_comb begin
      pos       = LANE_POS_W'(ctrl.base_pos) + LANE_POS_W'(lane_idx);
      in_word   = COUNT_W'(lane_idx) < ctrl.count;
      in_range  = pos < LANE_POS_W'(MAX_PACKET_BYTES);
      summed    = in_word && in_range && (CMP_W'(pos) >= CMP_W'(ctrl.start));
      // Odd distance from the start puts the byte in the high half.
      high_half = pos[0] ^ ctrl.start[0];
      if (!summed) begin
         value = '0;
      end else if (high_half) begin
         value = {byte_in, {BYTE_W{1'b0}}};
      end else begin
         value = {{BYTE_W{1'b0}}, byte_in};
      end
   end

endmodule

`default_nettype wire

@@ rtl/rxcsum_merge.sv @@
// Merging stage: adds the lane values of one item and folds them to 16 bits.
// Depends on rxcsum_pkg for the lane count and widths.
`default_nettype none

module rxcsum_merge (
   input  logic [rxcsum_pkg::LANES-1:0][rxcsum_pkg::CSUM_W-1:0] lane_values,
   output logic [rxcsum_pkg::CSUM_W-1:0]                        word_sum
);
   import rxcsum_pkg::*;

   logic [SUM_W-1:0]  total;
   logic [CSUM_W:0]   fold1;

   always_comb begin
      total = '0;
      for (int i = 0; i < LANES; i++) begin
         total = total + SUM_W'(lane_values[i]);
      end
      // Two folds; the second cannot carry out again.
      fold1    = (CSUM_W+1)'(total[CSUM_W-1:0]) + (CSUM_W+1)'(total[SUM_W-1:CSUM_W]);
      word_sum = fold1[CSUM_W-1:0] + CSUM_W'(fold1[CSUM_W]);
   end

endmodule

`default_nettype wire

@@ rtl/rx_partial_checksum_completion.sv @@
// Receive checksum completion: one 64-bit packet word is taken every cycle, except
// while stage one stalls on a full output register. A last word passes through the
// stage-one register and then the output register, where its result waits until taken.
// Throughput: one item per cycle, set by the byte position update and the lane merge.
// Reset: synchronous, active high; clears position, oversize flag, held header
// fields, the running sum and both pipeline valid flags.
`default_nettype none

module rx_partial_checksum_completion (
   input  logic         clock,
   input  logic         reset,
   rxcsum_req_if.sink   req_ch,
   rxcsum_rsp_if.source rsp_ch
);
   import rxcsum_pkg::*;

   localparam int CMP_W = ((POS_W > SLOT_W) ? POS_W : SLOT_W) + 1;

   // Stage one holds the folded sum of one word and, for a last word, the
   // finished header checks.
   typedef struct packed {
      logic [CSUM_W-1:0]  word_sum;
      logic               fresh;
      logic               last;
      logic               apply;
      logic               err;
      logic [FIELD_W-1:0] slot;
      logic [LEN_W-1:0]   len;
   } stage_type;

   typedef struct packed {
      logic [CSUM_W-1:0]  checksum;
      logic [FIELD_W-1:0] insert_offset;
      logic               apply_csum;
      logic               header_error;
      logic [LEN_W-1:0]   packet_length;
   } result_type;

   // Packet state that the next word depends on.
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               ovs_ff, ovs_in;
   logic               held_needs_ff, held_needs_in;
   logic [FIELD_W-1:0] held_start_ff, held_start_in;
   logic [FIELD_W-1:0] held_offset_ff, held_offset_in;

   logic               s1_valid_ff, s1_valid_in;
   stage_type          s1_ff, s1_in;
   logic [CSUM_W-1:0]  acc_ff, acc_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;

   logic                            accept;
   logic                            out_free;
   logic                            s1_adv;
   logic                            first;
   logic [POS_W-1:0]                base_pos;
   logic                            needs_eff;
   logic [FIELD_W-1:0]              start_eff;
   logic [FIELD_W-1:0]              offset_eff;
   logic [COUNT_W-1:0]              count_eff;
   logic [POS_W:0]                  end_pos;
   logic                            over_word;
   logic [POS_W-1:0]                new_pos;
   logic                            ovs_now;
   logic [SLOT_W-1:0]               slot;
   logic                            slot_bad;
   logic                            err_now;
   lane_ctrl_type                   lane_ctrl;
   logic [LANES-1:0][CSUM_W-1:0]    lane_values;
   logic [CSUM_W-1:0]               word_sum;
   logic [CSUM_W-1:0]               acc_sum;

   // The output register parts the two sides; stage one stalls only when a
   // last word meets a full output register that is not being drained.
   always_comb begin
      out_free      = !out_valid_ff || rsp_ch.ready;
      s1_adv        = s1_valid_ff && (!s1_ff.last || out_free);
      req_ch.ready  = !s1_valid_ff || s1_adv;
      accept        = req_ch.valid && req_ch.ready;
   end

   // Header fields come straight from the item on a first word.
   always_comb begin
      first      = req_ch.first_word;
      base_pos   = first ? '0 : pos_ff;
      needs_eff  = first ? req_ch.needs_csum  : held_needs_ff;
      start_eff  = first ? req_ch.start_byte  : held_start_ff;
      offset_eff = first ? req_ch.slot_offset : held_offset_ff;
      count_eff  = (req_ch.byte_count > COUNT_W'(LANES)) ? COUNT_W'(LANES)
                                                         : req_ch.byte_count;
      end_pos    = (POS_W+1)'(base_pos) + (POS_W+1)'(count_eff);
      // Any byte past the maximum marks the packet oversized and is dropped.
      over_word  = end_pos > (POS_W+1)'(MAX_PACKET_BYTES);
      new_pos    = over_word ? POS_W'(MAX_PACKET_BYTES) : end_pos[POS_W-1:0];
      ovs_now    = (first ? 1'b0 : ovs_ff) || over_word;
      slot       = SLOT_W'(start_eff) + SLOT_W'(offset_eff);
      // The slot needs two bytes below the length; this also covers a
      // length under two without an unsigned wrap.
      slot_bad   = (CMP_W'(slot) + CMP_W'(2)) > CMP_W'(new_pos);
      err_now    = ovs_now || (needs_eff && slot_bad);
   end

   always_comb begin
      lane_ctrl.base_pos = base_pos;
      lane_ctrl.start    = start_eff;
      lane_ctrl.count    = count_eff;
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      rxcsum_lane u_lane (
         .ctrl     (lane_ctrl),
         .lane_idx (LANE_IDX_W'(g)),
         .byte_in  (req_ch.data_word[g*BYTE_W +: BYTE_W]),
         .value    (lane_values[g])
      );
   end

   rxcsum_merge u_merge (
      .lane_values (lane_values),
      .word_sum    (word_sum)
   );

   // Packet state updates at each taken item; a last word clears the
   // position and oversize flag, while the held header stays.
   always_comb begin
      pos_in         = pos_ff;
      ovs_in         = ovs_ff;
      held_needs_in  = held_needs_ff;
      held_start_in  = held_start_ff;
      held_offset_in = held_offset_ff;
      if (accept) begin
         held_needs_in  = needs_eff;
         held_start_in  = start_eff;
         held_offset_in = offset_eff;
         if (req_ch.last_word) begin
            pos_in = '0;
            ovs_in = 1'b0;
         end else begin
            pos_in = new_pos;
            ovs_in = ovs_now;
         end
      end
   end

   // A zero base position means no byte of this packet was taken yet, so the
   // running sum is restarted; any earlier bytes of the packet summed to zero.
   always_comb begin
      s1_in.word_sum = word_sum;
      s1_in.fresh    = (base_pos == '0);
      s1_in.last     = req_ch.last_word;
      s1_in.apply    = needs_eff && !err_now;
      s1_in.err      = err_now;
      s1_in.slot     = slot[FIELD_W-1:0];
      s1_in.len      = LEN_W'(new_pos);
      s1_valid_in    = accept || (s1_valid_ff && !s1_adv);
   end

   // Stage two folds the word into the running sum and forms the result.
   always_comb begin
      acc_sum = csum_add(s1_ff.fresh ? '0 : acc_ff, s1_ff.word_sum);
      acc_in  = s1_adv ? acc_sum : acc_ff;

      out_in.checksum      = s1_ff.apply ? ~acc_sum : '0;
      out_in.insert_offset = s1_ff.apply ? s1_ff.slot : '0;
      out_in.apply_csum    = s1_ff.apply;
      out_in.header_error  = s1_ff.err;
      out_in.packet_length = s1_ff.len;

      if (s1_adv && s1_ff.last) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         ovs_ff         <= 1'b0;
         held_needs_ff  <= 1'b0;
         held_start_ff  <= '0;
         held_offset_ff <= '0;
         acc_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         ovs_ff         <= ovs_in;
         held_needs_ff  <= held_needs_in;
         held_start_ff  <= held_start_in;
         held_offset_ff <= held_offset_in;
         acc_ff         <= acc_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv && s1_ff.last) begin
         out_ff <= out_in;
      end
   end

   always_comb begin
      rsp_ch.valid         = out_valid_ff;
      rsp_ch.checksum      = out_ff.checksum;
      rsp_ch.insert_offset = out_ff.insert_offset;
      rsp_ch.apply_csum    = out_ff.apply_csum;
      rsp_ch.header_error  = out_ff.header_error;
      rsp_ch.packet_length = out_ff.packet_length;
   end

   // After reset neither pipeline stage holds an item.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !out_valid_ff))
      else $error("pipeline not empty after reset");

   // A stalled stage-one item keeps its contents.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("stalled stage-one item changed");

   // The byte position never exceeds the packet limit.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_PACKET_BYTES))
      else $error("byte position past limit");

   // A result that is applied never carries an error.
   a_apply_no_err: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.apply_csum) |-> !out_ff.header_error)
      else $error("applied result flagged as error");

   // A last word in stage one is never dropped while the output is full.
   a_last_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.last && !out_free) |=> s1_valid_ff)
      else $error("last word lost while output full");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rx_partial_checksum_completion: a directed table, a size-limit packet,
// then random packets, each result checked against a table literal or a predictor in this file.
// Depends on rxcsum_pkg and the rxcsum_req_if / rxcsum_rsp_if channel interfaces.

module testbench;
   import rxcsum_pkg::*;

   // One packet word as it is driven on the input channel.
   typedef struct packed {
      logic [DATA_W-1:0]  data_word;
      logic [COUNT_W-1:0] byte_count;
      logic               first_word;
      logic               last_word;
      logic               needs_csum;
      logic [FIELD_W-1:0] start_byte;
      logic [FIELD_W-1:0] slot_offset;
   } pkt_word_type;

   // One result as it leaves the result channel.
   typedef struct packed {
      logic [CSUM_W-1:0]  checksum;
      logic [FIELD_W-1:0] insert_offset;
      logic               apply_csum;
      logic               header_error;
      logic [LEN_W-1:0]   packet_length;
   } csum_result_type;

   // A row of the directed table. When has_literal is set, the result written in the row
   // is what the block must produce, and the predictor's own answer is not used.
   typedef struct packed {
      pkt_word_type    word;
      logic            has_literal;
      csum_result_type want;
   } stim_row_type;

   localparam int IDLE_LIMIT   = 2000;
   localparam int MAX_WAIT     = 10;
   localparam int RANDOM_ITEMS = 120;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_WORDS    = 264;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rxcsum_req_if req_if ();
   rxcsum_rsp_if rsp_if ();

   rx_partial_checksum_completion u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Predictor state: the packet being summed and the header fields held from its first word.
   logic [31:0]        sum_acc    = '0;
   logic [LEN_W-1:0]   byte_pos   = '0;
   logic               too_long   = 1'b0;
   logic               hdr_needs  = 1'b0;
   logic [FIELD_W-1:0] hdr_start  = '0;
   logic [FIELD_W-1:0] hdr_offset = '0;

   csum_result_type expected_results[$];
   stim_row_type    directed_rows[$];

   int mismatches   = 0;
   int idle_cycles  = 0;
   int random_items = 0;
   bit send_quiet   = 1'b0;
   bit recv_quiet   = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Folds a 32-bit sum into 16 bits with end-around carry, twice so that the
   // carry of the first fold is absorbed as well.
   function automatic logic [CSUM_W-1:0] fold_to_16(input logic [31:0] s);
      logic [31:0] t;
      t = {16'h0, s[15:0]} + {16'h0, s[31:16]};
      t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
      return t[15:0];
   endfunction

   // Advances the predictor by one accepted word. On a last word it hands back the
   // result the block owes for the packet and clears the per-packet state; the held
   // header fields survive until the next first word.
   task automatic checksum_predict(input pkt_word_type w, output bit produced,
                                   output csum_result_type res);
      int unsigned       n;
      int                i;
      logic [7:0]        b;
      logic [LEN_W-1:0]  rel;
      logic [SLOT_W-1:0] slot;
      logic              err;
      n = (w.byte_count > 8) ? 8 : w.byte_count;
      if (w.first_word) begin
         sum_acc    = '0;
         byte_pos   = '0;
         too_long   = 1'b0;
         hdr_needs  = w.needs_csum;
         hdr_start  = w.start_byte;
         hdr_offset = w.slot_offset;
      end
      for (i = 0; i < n; i++) begin
         b = w.data_word[8*i +: 8];
         // A byte beyond the size limit is dropped and marks the packet as oversized;
         // the position does not move, so every later byte lands here as well.
         if (byte_pos >= MAX_PACKET_BYTES) begin
            too_long = 1'b1;
         end else begin
            if (byte_pos >= hdr_start) begin
               // Pairing is counted from the start offset: even bytes are low, odd are high.
               rel     = byte_pos - hdr_start;
               sum_acc = 32'(fold_to_16(sum_acc + (rel[0] ? {16'h0, b, 8'h0}
                                                           : {24'h0, b})));
            end
            byte_pos = byte_pos + 1'b1;
         end
      end
      produced = w.last_word;
      res      = '0;
      if (w.last_word) begin
         slot = SLOT_W'(hdr_start) + SLOT_W'(hdr_offset);
         err  = too_long;
         // The two-byte slot must lie wholly inside the packet; a packet under two
         // bytes has no room for it at all.
         if (hdr_needs && (byte_pos < 2 || slot > byte_pos - 2)) begin
            err = 1'b1;
         end
         if (hdr_needs && !err) begin
            res.checksum      = ~fold_to_16(sum_acc);
            res.insert_offset = slot[FIELD_W-1:0];
            res.apply_csum    = 1'b1;
         end
         res.header_error  = err;
         res.packet_length = byte_pos;
         sum_acc  = '0;
         byte_pos = '0;
         too_long = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   // Appends one row to the directed table.
   task automatic add_row(input logic [DATA_W-1:0] data, input logic [COUNT_W-1:0] count,
                          input logic first_word, last_word, needs,
                          input logic [FIELD_W-1:0] start, offset,
                          input logic has_literal,
                          input logic [CSUM_W-1:0] csum, input logic [FIELD_W-1:0] ins,
                          input logic apply, err, input logic [LEN_W-1:0] len);
      stim_row_type row;
      row.word        = {data, count, first_word, last_word, needs, start, offset};
      row.has_literal = has_literal;
      row.want        = {csum, ins, apply, err, len};
      directed_rows.push_back(row);
   endtask

   // Presents one word after a random gap and holds it until the block takes it. The
   // expectation is recorded at the edge of acceptance, well ahead of the result.
   task automatic send_word(input pkt_word_type w, input logic has_literal,
                            input csum_result_type want);
      int              gap;
      bit              produced;
      csum_result_type res;
      gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.data_word   <= w.data_word;
      req_if.byte_count  <= w.byte_count;
      req_if.first_word  <= w.first_word;
      req_if.last_word   <= w.last_word;
      req_if.needs_csum  <= w.needs_csum;
      req_if.start_byte  <= w.start_byte;
      req_if.slot_offset <= w.slot_offset;
      req_if.valid       <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      checksum_predict(w, produced, res);
      if (produced) begin
         expected_results.push_back(has_literal ? want : res);
      end
   endtask

   // Stops offering words and waits until every owed result has been taken.
   task automatic hold_until_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Sends one random packet. Most packets are well formed: a first word carrying the
   // header, a checksum slot inside the packet and a closing last word. A minority carry
   // a slot anywhere in the field range, odd byte counts, no first word (so they run
   // under the previous header) or no last word (so the next first word restarts them).
   // With full_words set every word carries eight bytes, for the size-limit packets.
   task automatic send_packet(input int n_words, input bit full_words);
      logic [COUNT_W-1:0] counts [0:MAX_WORDS-1];
      int                 len;
      int                 start;
      int                 offset;
      int                 i;
      int                 r;
      bit                 with_first;
      bit                 keep_last;
      bit                 needs;
      pkt_word_type       w;
      len = 0;
      for (i = 0; i < n_words; i++) begin
         r = $urandom_range(0, 19);
         if (full_words) begin
            counts[i] = 4'd8;
         end else if (r == 0) begin
            counts[i] = 4'd0;
         end else if (r == 1) begin
            counts[i] = COUNT_W'($urandom_range(9, 15));
         end else if (r < 6 || i == n_words - 1) begin
            counts[i] = COUNT_W'($urandom_range(1, 8));
         end else begin
            counts[i] = 4'd8;
         end
         len += (counts[i] > 8) ? 8 : counts[i];
      end
      if (len > MAX_PACKET_BYTES) len = MAX_PACKET_BYTES;
      needs = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 3) != 0) begin
         start  = $urandom_range(0, (len < 2047) ? len : 2047);
         offset = (len >= start + 2) ? $urandom_range(0, len - 2 - start)
                                     : $urandom_range(0, 3);
      end else begin
         start  = $urandom_range(0, 2047);
         offset = $urandom_range(0, 2047);
      end
      with_first = full_words || ($urandom_range(0, 9) != 0);
      keep_last  = full_words || ($urandom_range(0, 14) != 0);
      for (i = 0; i < n_words; i++) begin
         w.data_word = {$urandom, $urandom};
         r = $urandom_range(0, 15);
         if (r == 0) w.data_word = {DATA_W{1'b1}};
         if (r == 1) w.data_word = '0;
         w.byte_count = counts[i];
         w.first_word = (i == 0) && with_first;
         w.last_word  = (i == n_words - 1) && keep_last;
         if (w.first_word) begin
            w.needs_csum  = needs;
            w.start_byte  = FIELD_W'(start);
            w.slot_offset = FIELD_W'(offset);
         end else begin
            // Header fields on later words are ignored by the block; fill them with noise.
            w.needs_csum  = 1'($urandom_range(0, 1));
            w.start_byte  = FIELD_W'($urandom_range(0, 2047));
            w.slot_offset = FIELD_W'($urandom_range(0, 2047));
         end
         send_word(w, 1'b0, '0);
      end
   endtask

   // Result side: a random stall before each result, sometimes long runs without stalls.
   // Every accepted result is compared with the oldest one still owed.
   initial begin : result_sink
      int              stall;
      csum_result_type got;
      csum_result_type want;
      rsp_if.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) recv_quiet = !recv_quiet;
         stall = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall != 0) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         got = {rsp_if.checksum, rsp_if.insert_offset, rsp_if.apply_csum,
                rsp_if.header_error, rsp_if.packet_length};
         if (expected_results.size() == 0) begin
            report_mismatch("result arrived while none was owed");
         end else begin
            want = expected_results.pop_front();
            check_field("checksum", 32'(got.checksum), 32'(want.checksum));
            check_field("insert_offset", 32'(got.insert_offset), 32'(want.insert_offset));
            check_field("apply_csum", 32'(got.apply_csum), 32'(want.apply_csum));
            check_field("header_error", 32'(got.header_error), 32'(want.header_error));
            check_field("packet_length", 32'(got.packet_length), 32'(want.packet_length));
         end
      end
   end

   // Watchdog: a long stretch with no item moving on either channel means the block hung.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int n;
      req_if.valid       = 1'b0;
      req_if.data_word   = '0;
      req_if.byte_count  = '0;
      req_if.first_word  = 1'b0;
      req_if.last_word   = 1'b0;
      req_if.needs_csum  = 1'b0;
      req_if.start_byte  = '0;
      req_if.slot_offset = '0;

      // Directed table. Columns: data, byte count, first, last, needs_csum, start, offset,
      // then, where the answer is plain, the literal result: checksum, insert offset,
      // apply, error, length.
      // Straight after reset, a lone last word runs under the cleared header: no completion.
      add_row(64'h0000_0000_0000_0201, 4'd2,  1'b0, 1'b1, 1'b0, 11'd0,    11'd0,    1'b1,
              16'h0000, 11'd0, 1'b0, 1'b0, 12'd2);
      // Single-word packets: two bytes of ones sum to all ones, so the checksum is zero.
      add_row(64'h0000_0000_0000_FFFF, 4'd2,  1'b1, 1'b1, 1'b1, 11'd0,    11'd0,    1'b1,
              16'h0000, 11'd0, 1'b1, 1'b0, 12'd2);
      // Short packets: one byte, then none, with completion requested, are errors.
      add_row(64'h0000_0000_0000_00AB, 4'd1,  1'b1, 1'b1, 1'b1, 11'd0,    11'd0,    1'b1,
              16'h0000, 11'd0, 1'b0, 1'b1, 12'd1);
      add_row(64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 1'b1, 1'b1, 11'd0,    11'd0,    1'b1,
              16'h0000, 11'd0, 1'b0, 1'b1, 12'd0);
      // An empty packet without completion is not an error.
      add_row(64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 1'b1, 1'b0, 11'd0,    11'd0,    1'b1,
              16'h0000, 11'd0, 1'b0, 1'b0, 12'd0);
      // A byte count of fifteen counts as eight; the slot at six is the last that fits.
      add_row(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b1, 1'b1, 11'd0,    11'd6,    1'b1,
              16'h0000, 11'd6, 1'b1, 1'b0, 12'd8);
      // One byte further the slot overhangs the packet.
      add_row(64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1, 1'b1, 1'b1, 11'd0,    11'd7,    1'b1,
              16'h0000, 11'd0, 1'b0, 1'b1, 12'd8);
      // Largest start and offset: out of bounds when requested, ignored when not.
      add_row(64'h0000_0000_0000_0000, 4'd8,  1'b1, 1'b1, 1'b1, 11'd2047, 11'd2047, 1'b1,
              16'h0000, 11'd0, 1'b0, 1'b1, 12'd8);
      add_row(64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1, 1'b1, 1'b0, 11'd2047, 11'd2047, 1'b1,
              16'h0000, 11'd0, 1'b0, 1'b0, 12'd8);
      // All-zero data sums to zero, so the inverted checksum is all ones.
      add_row(64'h0000_0000_0000_0000, 4'd8,  1'b1, 1'b1, 1'b1, 11'd0,    11'd0,    1'b1,
              16'hFFFF, 11'd0, 1'b1, 1'b0, 12'd8);
      // Odd start offset, so the pairing is shifted by one byte.
      add_row(64'h0807_0605_0403_0201, 4'd9,  1'b1, 1'b1, 1'b1, 11'd1,    11'd0,    1'b0,
              '0, '0, 1'b0, 1'b0, '0);
      // Four-word packet: a word of no bytes in the middle and an odd final byte count.
      add_row(64'hA5A5_A5A5_A5A5_A5A5, 4'd8,  1'b1, 1'b0, 1'b1, 11'd3,    11'd2,    1'b0,
              '0, '0, 1'b0, 1'b0, '0);
      add_row(64'h5A5A_5A5A_5A5A_5A5A, 4'd0,  1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0,
              '0, '0, 1'b0, 1'b0, '0);
      add_row(64'h0123_4567_89AB_CDEF, 4'd8,  1'b0, 1'b0, 1'b0, 11'd0,    11'd0,    1'b0,
              '0, '0, 1'b0, 1'b0, '0);
      add_row(64'hFEDC_BA98_7654_3210, 4'd3,  1'b0, 1'b1, 1'b0, 11'd0,    11'd0,    1'b0,
              '0, '0, 1'b0, 1'b0, '0);
      // No first word after a last word: a new packet under the held header.
      add_row(64'h3C3C_C3C3_0F0F_F0F0, 4'd8,  1'b0, 1'b1, 1'b0, 11'd0,    11'd0,    1'b0,
              '0, '0, 1'b0, 1'b0, '0);
      // Start beyond the end of a two-word packet: the slot cannot fit.
      add_row(64'h1122_3344_5566_7788, 4'd8,  1'b1, 1'b0, 1'b1, 11'd100,  11'd0,    1'b0,
              '0, '0, 1'b0, 1'b0, '0);
      add_row(64'h99AA_BBCC_DDEE_FF00, 4'd8,  1'b0, 1'b1, 1'b0, 11'd0,    11'd0,    1'b1,
              16'h0000, 11'd0, 1'b0, 1'b1, 12'd16);
      // Nine-byte packet whose summing starts on the last byte of the first word.
      add_row(64'hDEAD_BEEF_CAFE_F00D, 4'd8,  1'b1, 1'b0, 1'b1, 11'd7,    11'd0,    1'b0,
              '0, '0, 1'b0, 1'b0, '0);
      add_row(64'h0000_0000_0000_0081, 4'd1,  1'b0, 1'b1, 1'b0, 11'd0,    11'd0,    1'b0,
              '0, '0, 1'b0, 1'b0, '0);
      // A packet left without a last word is cut off by the next first word.
      add_row(64'h7777_7777_8888_8888, 4'd4,  1'b1, 1'b0, 1'b1, 11'd0,    11'd0,    1'b0,
              '0, '0, 1'b0, 1'b0, '0);
      add_row(64'h0000_0000_1234_5678, 4'd4,  1'b1, 1'b0, 1'b1, 11'd0,    11'd2,    1'b0,
              '0, '0, 1'b0, 1'b0, '0);
      // Header fields at their extremes on a later word must be ignored.
      add_row(64'h6B6B_9494_6B6B_9494, 4'd8,  1'b0, 1'b1, 1'b1, 11'd2047, 11'd2047, 1'b0,
              '0, '0, 1'b0, 1'b0, '0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         send_word(directed_rows[k].word, directed_rows[k].has_literal, directed_rows[k].want);
      end
      hold_until_drained();

      // Size limit: one word over the maximum, so the count saturates and the packet
      // is flagged. No gaps are left here, as this packet is long.
      send_quiet = 1'b1;
      send_packet(MAX_PACKET_BYTES / 8 + 1, 1'b1);
      send_quiet = 1'b0;

      // Random packets of one to eight words, switching now and then between gapped and
      // back-to-back traffic, with an occasional pause until all results are in.
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) send_quiet = !send_quiet;
         if ($urandom_range(0, 39) == 0) hold_until_drained();
         n = $urandom_range(1, 8);
         send_packet(n, 1'b0);
         random_items += n;
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/rxcsum_pkg.sv
rtl/rxcsum_req_if.sv
rtl/rxcsum_rsp_if.sv
rtl/rxcsum_lane.sv
rtl/rxcsum_merge.sv
rtl/rx_partial_checksum_completion.sv
bench/testbench.sv
